// File: src/chroma_to_magnitude_and_hue_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for chroma_to_magnitude_and_hue
// Immediate-implication and next-cycle-implication checks, clocked on clk and
// disabled while arst_n is low. Empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef CHROMA_TO_MAGNITUDE_AND_HUE_DEFINES_SVH
`define CHROMA_TO_MAGNITUDE_AND_HUE_DEFINES_SVH

`ifndef SYNTH
`define C2MH_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("c2mh check failed");
`else
`define C2MH_ASSERT_IMPL(name, ante, cons)
`endif

`ifndef SYNTH
`define C2MH_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("c2mh check failed");
`else
`define C2MH_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// File: src/c2mh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2mh_pkg
// Widths, angle constants, pipeline types and the rounding and arctangent
// table functions shared by the chroma-to-polar datapath.
// ----------------------------------------------------------------------------
package c2mh_pkg;

	localparam int unsigned DiffW     = 9;
	localparam int unsigned AbsW      = 9;
	localparam int unsigned SqW       = 18;
	localparam int unsigned SatW      = 9;
	localparam int unsigned HueW      = 9;
	localparam int unsigned SqrtCells = SatW;
	localparam int unsigned IntW      = 11;
	localparam int unsigned FracW     = 52;
	localparam int unsigned VecW      = IntW + FracW;
	localparam int unsigned QFrac     = 48;
	localparam int unsigned DegW      = 57;
	localparam int unsigned MantW     = 24;
	localparam int unsigned ShW       = $clog2(DegW);
	localparam int unsigned DefStages = 48;
	localparam int unsigned MaxHue    = 359;

	localparam logic [DegW-1:0] PiQ48     = 57'h3243F6A8885A3;
	localparam logic [DegW-1:0] HalfPiQ48 = 57'h1921FB54442D2;
	localparam logic [127:0]    DegNum    = 128'd180000000;
	localparam logic [127:0]    DegDen    = 128'd3141592;
	localparam logic [DegW-1:0] Deg180    = DegW'((128'(PiQ48) * DegNum) / DegDen);
	localparam logic [DegW-1:0] Deg90     = DegW'((128'(HalfPiQ48) * DegNum) / DegDen);
	localparam logic [DegW-1:0] Full360   = DegW'(360) << QFrac;
	localparam real             DegPerRad = 180.0 / 3.141592;

	typedef struct packed {
		logic signed [VecW-1:0] x;
		logic signed [VecW-1:0] y;
		logic signed [DegW-1:0] z;
	} vec_t;

	typedef struct packed {
		logic valid;
		logic x_neg;
		logic y_neg;
		logic on_x;
		logic on_y;
	} tag_t;

	typedef struct packed {
		logic [SqW-1:0] resid;
		logic [SqW-1:0] root;
	} root_t;

	// atan(2^-idx) in scaled degrees, Q48
	function automatic logic signed [DegW-1:0] atan_step(input int unsigned idx);
		real ang;
		ang = $atan(2.0 ** (-1.0 * real'(idx))) * DegPerRad * (2.0 ** QFrac);
		return DegW'(longint'(ang));
	endfunction

	// keep 24 significant bits, round to nearest, ties to even
	function automatic logic [DegW-1:0] round24(input logic [DegW-1:0] v);
		logic [ShW-1:0]  sh;
		logic [DegW-1:0] unit;
		logic [DegW-1:0] half;
		logic [DegW-1:0] low;
		logic [DegW-1:0] base;
		sh = '0;
		for (int p = MantW; p < DegW; p++) begin
			if (v[p]) begin
				sh = ShW'(p - MantW + 1);
			end
		end
		unit = DegW'(1) << sh;
		half = unit >> 1;
		low  = v & (unit - DegW'(1));
		base = v - low;
		if (sh == '0) begin
			base = v;
		end else if (low > half || (low == half && v[sh])) begin
			base = base + unit;
		end
		return base;
	endfunction

endpackage

// File: src/c2mh_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2mh_sqrt_cell
// One digit of the restoring integer square root; resolves one result bit
// and hands remainder and partial root to the next cell.
// ----------------------------------------------------------------------------
module c2mh_sqrt_cell #(
	parameter int unsigned Pos = 0
) (
	input  logic            clk,
	input  c2mh_pkg::root_t root_in,
	output c2mh_pkg::root_t root_out
);
	import c2mh_pkg::*;

	localparam logic [SqW-1:0] Bit = SqW'(1) << (2 * Pos);

	logic [SqW-1:0] trial;
	root_t          nxt;
	root_t          root_q;

	assign trial = root_in.root + Bit;

	always_comb begin
		if (root_in.resid >= trial) begin
			nxt.resid = root_in.resid - trial;
			nxt.root  = (root_in.root >> 1) + Bit;
		end else begin
			nxt.resid = root_in.resid;
			nxt.root  = root_in.root >> 1;
		end
	end

	always_ff @(posedge clk) begin
		root_q <= nxt;
	end

	assign root_out = root_q;

endmodule

// File: src/c2mh_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2mh_cordic_cell
// One vectoring micro-rotation: drive y toward zero and accumulate the
// rotated angle in scaled degrees.
// ----------------------------------------------------------------------------
module c2mh_cordic_cell #(
	parameter int unsigned Idx = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  c2mh_pkg::vec_t vec_in,
	input  c2mh_pkg::tag_t tag_in,
	output c2mh_pkg::vec_t vec_out,
	output c2mh_pkg::tag_t tag_out
);
	import c2mh_pkg::*;

	localparam logic signed [DegW-1:0] Step = atan_step(Idx);

	logic signed [VecW-1:0] x_sh;
	logic signed [VecW-1:0] y_sh;
	vec_t                   nxt;
	vec_t                   vec_q;
	tag_t                   tag_q;

	assign x_sh = vec_in.x >>> Idx;
	assign y_sh = vec_in.y >>> Idx;

	always_comb begin
		if (vec_in.y[VecW-1]) begin
			nxt.x = vec_in.x - y_sh;
			nxt.y = vec_in.y + x_sh;
			nxt.z = vec_in.z - Step;
		end else begin
			nxt.x = vec_in.x + y_sh;
			nxt.y = vec_in.y - x_sh;
			nxt.z = vec_in.z + Step;
		end
	end

	always_ff @(posedge clk) begin
		vec_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else begin
			tag_q <= tag_in;
		end
	end

	assign vec_out = vec_q;
	assign tag_out = tag_q;

endmodule

// File: src/c2mh_deg_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c2mh_deg_round
// Map the first-quadrant angle to the full circle, apply single-precision
// rounding and the wrap by 360, and truncate to whole degrees.
// ----------------------------------------------------------------------------
module c2mh_deg_round (
	input  logic                          clk,
	input  logic                          arst_n,
	input  c2mh_pkg::tag_t                tag_in,
	input  logic signed [c2mh_pkg::DegW-1:0] ang_in,
	output logic                          valid_out,
	output logic [c2mh_pkg::HueW-1:0]     hue_out
);
	import c2mh_pkg::*;

	logic [DegW-1:0] deg_d;
	logic [DegW-1:0] deg_s1;
	logic            y_neg_s1;
	logic [DegW-1:0] f_s2;
	logic            y_neg_s2;
	logic [DegW-1:0] g_s3;
	logic            wrap_s3;
	logic [DegW-1:0] h_d;
	logic [HueW-1:0] hue_s4;
	logic            valid_s1;
	logic            valid_s2;
	logic            valid_s3;
	logic            valid_s4;

	always_comb begin
		if (tag_in.on_x) begin
			deg_d = tag_in.x_neg ? Deg180 : '0;
		end else if (tag_in.on_y) begin
			deg_d = Deg90;
		end else if (tag_in.x_neg) begin
			deg_d = Deg180 - ang_in;
		end else begin
			deg_d = ang_in;
		end
	end

	assign h_d = wrap_s3 ? round24(g_s3) : g_s3;

	always_ff @(posedge clk) begin
		deg_s1   <= deg_d;
		y_neg_s1 <= tag_in.y_neg;
		f_s2     <= round24(deg_s1);
		y_neg_s2 <= y_neg_s1;
		wrap_s3  <= y_neg_s2 && (f_s2 != '0);
		g_s3     <= (y_neg_s2 && (f_s2 != '0)) ? (Full360 - f_s2) : f_s2;
		hue_s4   <= h_d[QFrac +: HueW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= tag_in.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	assign valid_out = valid_s4;
	assign hue_out   = hue_s4;

endmodule

// File: src/chroma_to_magnitude_and_hue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chroma_to_magnitude_and_hue
// Cartesian-to-polar conversion of a pixel's color-difference pair: floor of
// the magnitude as saturation, truncated scaled angle as hue in degrees.
//
//   channel  | direction | handshake           | payload
//   ---------+-----------+---------------------+--------------------------
//   command  | in        | start / busy        | red_diff, blue_diff
//   result   | out       | done (no backpress) | saturation, hue_degrees
//
// One pixel per clock while busy is low. The entry stage loads on the
// accepting edge, then the CORDIC cell chain and four rounding stages
// follow, and done rises out of the last rounding stage; the square-root
// cells run alongside.
// busy is high in reset and drops at the next clock edge; reset clears the valid
// flags of every stage. The receiver takes each result in the cycle of done.
// ----------------------------------------------------------------------------
`include "chroma_to_magnitude_and_hue_defines.svh"

module chroma_to_magnitude_and_hue #(
	parameter int unsigned Stages = c2mh_pkg::DefStages
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [c2mh_pkg::DiffW-1:0]  red_diff,
	input  logic signed [c2mh_pkg::DiffW-1:0]  blue_diff,
	output logic                               done,
	output logic [c2mh_pkg::SatW-1:0]          saturation,
	output logic [c2mh_pkg::HueW-1:0]          hue_degrees
);
	import c2mh_pkg::*;

	localparam int unsigned SatDelay = Stages - 5;
	localparam int unsigned Latency  = Stages + 5;

	logic            busy_q;
	logic            accept;
	logic [AbsW-1:0] a_d;
	logic [AbsW-1:0] b_d;
	logic [SqW-1:0]  sq_d;
	vec_t            vec_s1;
	tag_t            tag_s1;
	root_t           root_s1;
	vec_t            vec_c [Stages+1];
	tag_t            tag_c [Stages+1];
	root_t           root_c [SqrtCells+1];
	logic [SatW-1:0] sat_q [SatDelay];

	assign accept = start && !busy_q;
	assign a_d    = blue_diff[DiffW-1] ? AbsW'(-blue_diff) : AbsW'(blue_diff);
	assign b_d    = red_diff[DiffW-1] ? AbsW'(-red_diff) : AbsW'(red_diff);
	assign sq_d   = SqW'(a_d) * SqW'(a_d) + SqW'(b_d) * SqW'(b_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			tag_s1 <= '0;
		end else begin
			busy_q       <= 1'b0;
			tag_s1.valid <= accept;
			tag_s1.x_neg <= blue_diff[DiffW-1];
			tag_s1.y_neg <= red_diff[DiffW-1];
			tag_s1.on_x  <= (b_d == '0);
			tag_s1.on_y  <= (a_d == '0);
		end
	end

	always_ff @(posedge clk) begin
		vec_s1.x      <= {{(VecW-AbsW-FracW){1'b0}}, a_d, {FracW{1'b0}}};
		vec_s1.y      <= {{(VecW-AbsW-FracW){1'b0}}, b_d, {FracW{1'b0}}};
		vec_s1.z      <= '0;
		root_s1.resid <= sq_d;
		root_s1.root  <= '0;
	end

	assign vec_c[0]  = vec_s1;
	assign tag_c[0]  = tag_s1;
	assign root_c[0] = root_s1;

	for (genvar i = 0; i < Stages; i++) begin : g_cordic
		c2mh_cordic_cell #(
			.Idx(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vec_in  (vec_c[i]),
			.tag_in  (tag_c[i]),
			.vec_out (vec_c[i+1]),
			.tag_out (tag_c[i+1])
		);
	end

	for (genvar k = 0; k < SqrtCells; k++) begin : g_sqrt
		c2mh_sqrt_cell #(
			.Pos(SqrtCells - 1 - k)
		) u_cell (
			.clk      (clk),
			.root_in  (root_c[k]),
			.root_out (root_c[k+1])
		);
	end

	always_ff @(posedge clk) begin
		sat_q[0] <= root_c[SqrtCells].root[SatW-1:0];
		for (int i = 1; i < SatDelay; i++) begin
			sat_q[i] <= sat_q[i-1];
		end
	end

	c2mh_deg_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_in    (tag_c[Stages]),
		.ang_in    (vec_c[Stages].z),
		.valid_out (done),
		.hue_out   (hue_degrees)
	);

	assign busy       = busy_q;
	assign saturation = sat_q[SatDelay-1];

	`C2MH_ASSERT_IMPL(a_done_latency, done, $past(start && !busy, Latency))
	`C2MH_ASSERT_IMPL(a_zero_sat_hue, done && saturation == '0, hue_degrees == '0)
	`C2MH_ASSERT_IMPL(a_zero_input, start && !busy && red_diff == '0 && blue_diff == '0, ##Latency (done && saturation == '0))
	`C2MH_ASSERT_NEXT(a_hue_bound, 1'b1, !done || hue_degrees <= HueW'(MaxHue))

endmodule

// File: dv/chroma_to_magnitude_and_hue_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chroma_to_magnitude_and_hue_checker
// Watches the command and result channels of the chroma-to-polar block.
// Predicts saturation and hue for every accepted pixel in 64-bit fixed point:
// integer square root, Euler arctangent series in Q48 radians, scaled-degree
// conversion and 24-bit significand rounding. Compares each result, in
// order, with the oldest prediction. Reports mismatches and a running count.
// ----------------------------------------------------------------------------
module chroma_to_magnitude_and_hue_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic signed [c2mh_pkg::DiffW-1:0] red_diff,
	input  logic signed [c2mh_pkg::DiffW-1:0] blue_diff,
	input  logic                              done,
	input  logic [c2mh_pkg::SatW-1:0]         saturation,
	input  logic [c2mh_pkg::HueW-1:0]         hue_degrees,
	output int                                errors,
	output int                                pending
);

	import c2mh_pkg::*;

	localparam bit [63:0] PiRad     = 64'h3243F6A8885A3;
	localparam bit [63:0] HalfPiRad = 64'h1921FB54442D2;
	localparam bit [63:0] DegScale  = 64'd180000000;
	localparam bit [63:0] RadScale  = 64'd3141592;
	localparam bit [63:0] UnitQ48   = 64'd1 << 48;
	localparam bit [63:0] Turn      = 64'd360 << 48;

	typedef struct packed {
		logic [SatW-1:0] sat;
		logic [HueW-1:0] hue;
	} polar_t;

	polar_t polar_queue[$];

	function automatic bit [63:0] scaled_quot(bit [63:0] n, bit [63:0] m, bit [63:0] d);
		return (n / d) * m + ((n % d) * m) / d;
	endfunction

	function automatic bit [63:0] root_floor(bit [63:0] n);
		bit [63:0] rem;
		bit [63:0] root;
		bit [63:0] probe;
		rem   = n;
		root  = 0;
		probe = 64'd1 << 20;
		while (probe > rem) probe = probe >> 2;
		while (probe != 0) begin
			if (rem >= root + probe) begin
				rem  = rem - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic bit [63:0] atan_q48(bit [63:0] opp, bit [63:0] adj);
		bit [63:0] s;
		bit [63:0] opp2;
		bit [63:0] term;
		bit [63:0] sum;
		bit [63:0] k;
		s    = adj * adj + opp * opp;
		opp2 = opp * opp;
		term = scaled_quot(UnitQ48, adj * opp, s);
		sum  = term;
		for (k = 1; k < 100 && term != 0; k++) begin
			term = scaled_quot(term, opp2, s);
			term = scaled_quot(term, 2 * k, 2 * k + 1);
			sum  = sum + term;
		end
		return sum;
	endfunction

	function automatic bit [63:0] round_single(bit [63:0] v);
		int        p;
		int        sh;
		bit [63:0] unit;
		bit [63:0] half;
		bit [63:0] low;
		bit [63:0] base;
		if (v == 0) return 0;
		p = 63;
		while (!v[p]) p--;
		sh = p - 23;
		if (sh <= 0) return v;
		unit = 64'd1 << sh;
		half = unit >> 1;
		low  = v & (unit - 1);
		base = v - low;
		if (low > half || (low == half && base[sh])) base = base + unit;
		return base;
	endfunction

	function automatic polar_t predict_polar(logic signed [DiffW-1:0] y_in,
			logic signed [DiffW-1:0] x_in);
		longint    y;
		longint    x;
		bit [63:0] a;
		bit [63:0] b;
		bit [63:0] sat;
		bit [63:0] hue;
		bit [63:0] phi;
		bit [63:0] deg;
		bit [63:0] f;
		polar_t    res;
		y   = y_in;
		x   = x_in;
		a   = (x < 0) ? -x : x;
		b   = (y < 0) ? -y : y;
		sat = root_floor(a * a + b * b);
		hue = 0;
		if (sat != 0) begin
			if (b <= a) phi = atan_q48(b, a);
			else phi = HalfPiRad - atan_q48(a, b);
			if (x < 0) phi = PiRad - phi;
			deg = (phi / RadScale) * DegScale + ((phi % RadScale) * DegScale) / RadScale;
			f   = round_single(deg);
			if (y < 0 && f != 0) f = round_single(Turn - f);
			hue = f >> 48;
		end
		res.sat = sat[SatW-1:0];
		res.hue = hue[HueW-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		polar_t want;
		int     miss;
		if (!arst_n) begin
			errors  <= 0;
			pending <= 0;
			polar_queue.delete();
		end else begin
			miss = 0;
			if (done) begin
				if (polar_queue.size() == 0) begin
					$display("%0t: unexpected result expected none actual sat %0d hue %0d",
						$time, saturation, hue_degrees);
					miss++;
				end else begin
					want = polar_queue.pop_front();
					if (saturation !== want.sat) begin
						$display("%0t: saturation expected %0d actual %0d",
							$time, want.sat, saturation);
						miss++;
					end
					if (hue_degrees !== want.hue) begin
						$display("%0t: hue_degrees expected %0d actual %0d",
							$time, want.hue, hue_degrees);
						miss++;
					end
				end
			end
			if (start && !busy) polar_queue.push_back(predict_polar(red_diff, blue_diff));
			errors  <= errors + miss;
			pending <= polar_queue.size();
		end
	end

endmodule

// File: dv/chroma_to_magnitude_and_hue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chroma_to_magnitude_and_hue_tb
// Drives pixels into the chroma-to-polar block: corner vectors and axes
// first, then random vectors over several sender idle rates. The checker
// beside the block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module chroma_to_magnitude_and_hue_tb;

	import c2mh_pkg::*;

	localparam int CornerCount   = 22;
	localparam int PhaseCount    = 4;
	localparam int ItemsPerPhase = 182;
	localparam int DrainCycles   = 64;
	localparam int QuietLimit    = 3000;

	localparam logic signed [DiffW-1:0] CornerY[CornerCount] = '{
		0, -256, 255, -256, 255, 0, 0, -256, -1, -1, -100,
		255, 1, 0, 0, 1, 1, -1, -256, -1, 3, -255
	};
	localparam logic signed [DiffW-1:0] CornerX[CornerCount] = '{
		0, -256, 255, 255, -256, -256, -1, 0, 0, -1, -100,
		0, 0, 255, 1, 1, -1, 1, -1, -256, 4, 255
	};
	localparam int IdlePct[PhaseCount] = '{0, 80, 0, 19};

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic signed [DiffW-1:0] red_diff;
	logic signed [DiffW-1:0] blue_diff;
	logic                    done;
	logic [SatW-1:0]         saturation;
	logic [HueW-1:0]         hue_degrees;
	int                      errors;
	int                      pending;
	int                      quiet_cycles;

	chroma_to_magnitude_and_hue uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.red_diff    (red_diff),
		.blue_diff   (blue_diff),
		.done        (done),
		.saturation  (saturation),
		.hue_degrees (hue_degrees)
	);

	chroma_to_magnitude_and_hue_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.red_diff    (red_diff),
		.blue_diff   (blue_diff),
		.done        (done),
		.saturation  (saturation),
		.hue_degrees (hue_degrees),
		.errors      (errors),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QuietLimit);
		$display("DONE: errors detected");
		$finish;
	end

	task automatic transfer_pixel(input logic signed [DiffW-1:0] y,
			input logic signed [DiffW-1:0] x);
		red_diff  <= y;
		blue_diff <= x;
		start     <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	initial begin
		logic signed [DiffW-1:0] y;
		logic signed [DiffW-1:0] x;
		logic signed [DiffW-1:0] m;
		int                      kind;
		arst_n    = 1'b0;
		start     = 1'b0;
		red_diff  = '0;
		blue_diff = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < CornerCount; i++) transfer_pixel(CornerY[i], CornerX[i]);

		for (int ph = 0; ph < PhaseCount; ph++) begin
			for (int i = 0; i < ItemsPerPhase; i++) begin
				while ($urandom_range(0, 99) < IdlePct[ph]) begin
					start     <= 1'b0;
					red_diff  <= DiffW'($urandom);
					blue_diff <= DiffW'($urandom);
					@(posedge clk);
				end
				kind = $urandom_range(0, 9);
				m    = DiffW'($urandom);
				if (kind < 6) begin
					y = DiffW'($urandom);
					x = DiffW'($urandom);
				end else if (kind < 8) begin
					y = DiffW'(int'($urandom_range(0, 15)) - 8);
					x = DiffW'(int'($urandom_range(0, 15)) - 8);
				end else begin
					case ($urandom_range(0, 3))
						0: begin
							y = 0;
							x = m;
						end
						1: begin
							y = m;
							x = 0;
						end
						2: begin
							y = m;
							x = m;
						end
						default: begin
							y = m;
							x = -m;
						end
					endcase
				end
				transfer_pixel(y, x);
			end
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/c2mh_pkg.sv
src/c2mh_sqrt_cell.sv
src/c2mh_cordic_cell.sv
src/c2mh_deg_round.sv
src/chroma_to_magnitude_and_hue.sv
dv/chroma_to_magnitude_and_hue_checker.sv
dv/chroma_to_magnitude_and_hue_tb.sv
